FILE: hw/rtl/kvlp_pkg.sv
// Shared types, constants and the per-byte line classification function.
`default_nettype none
package kvlp_pkg;

   localparam int FIELD_BUFFER_BYTES = 125;
   localparam int KEY_LIMIT = FIELD_BUFFER_BYTES - 2;
   localparam int VALUE_LIMIT = FIELD_BUFFER_BYTES - 4;
   localparam int CNT_W = $clog2(KEY_LIMIT + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_EQ = 8'h3D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SP = 8'h20;

   localparam logic [1:0] KIND_KEY = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_ACCEPT = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] item_kind;
   } rsp_type;

   typedef struct packed {
      logic             in_value_part;
      logic [CNT_W-1:0] key_raw_count;
      logic [CNT_W-1:0] value_raw_count;
      logic             key_started;
      logic             value_started;
      logic             cr_held;
      logic             line_open;
      logic             length_overflow;
   } line_state_type;

   typedef struct packed {
      line_state_type st;
      logic           emit;
      rsp_type        item;
   } step_type;

   // Up to two results per transaction, slot a first.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    a;
      rsp_type    b;
   } push_type;

   // One ordinary (non-LF) byte applied to the line state.
   function automatic step_type plain_byte(input line_state_type s, input logic [7:0] b);
      step_type r;
      r = '0;
      r.st = s;
      r.item.out_byte = b;
      r.item.item_kind = KIND_KEY;
      r.st.line_open = 1'b1;
      if (!s.in_value_part) begin
         if (b == CH_EQ) begin
            r.st.in_value_part = 1'b1;
         end else begin
            if (s.key_raw_count < CNT_W'(KEY_LIMIT)) begin
               r.st.key_raw_count = s.key_raw_count + 1'b1;
            end else begin
               r.st.length_overflow = 1'b1;
            end
            if (s.key_started || (b != CH_SP)) begin
               r.st.key_started = 1'b1;
               r.emit = 1'b1;
            end
         end
      end else begin
         r.item.item_kind = KIND_VALUE;
         if (s.value_raw_count < CNT_W'(VALUE_LIMIT)) begin
            r.st.value_raw_count = s.value_raw_count + 1'b1;
         end else begin
            r.st.length_overflow = 1'b1;
         end
         if (s.value_started || (b != CH_SP)) begin
            r.st.value_started = 1'b1;
            r.emit = 1'b1;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/kvlp_front.sv
// Front end: keeps line state and turns each input byte into zero to two results.
`default_nettype none
module kvlp_front
   import kvlp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_accept,
   input  wire req_type req_data,
   output push_type     push
);

   line_state_type state_ff, state_in;

   line_state_type s0, s1;
   step_type       p1, p2;
   logic           v0, v1, v2;
   rsp_type        r0, r1, r2;
   logic           ok;

   always_comb begin
      s0 = state_ff;
      v0 = 1'b0;
      if (req_data.buffer_start) begin
         v0 = state_ff.line_open | state_ff.cr_held;
         s0 = '0;
      end
      r0.out_byte = 8'h00;
      r0.item_kind = KIND_REJECT;

      ok = s0.in_value_part && (s0.key_raw_count != '0) &&
           (s0.value_raw_count != '0) && !s0.length_overflow;

      // held CR turns into an ordinary byte ahead of this one
      p1 = plain_byte(s0, CH_CR);
      s1 = s0.cr_held ? p1.st : s0;
      s1.cr_held = 1'b0;
      p2 = plain_byte(s1, req_data.data_byte);

      if (req_data.data_byte == CH_LF) begin
         v1 = 1'b1;
         r1.out_byte = 8'h00;
         r1.item_kind = ok ? KIND_ACCEPT : KIND_REJECT;
         v2 = 1'b0;
         r2 = p2.item;
         state_in = '0;
      end else begin
         v1 = s0.cr_held & p1.emit;
         r1 = p1.item;
         r2 = p2.item;
         if (req_data.data_byte == CH_CR) begin
            v2 = 1'b0;
            state_in = s1;
            state_in.cr_held = 1'b1;
            state_in.line_open = 1'b1;
         end else begin
            v2 = p2.emit;
            state_in = p2.st;
         end
      end

      push.count = req_accept ? ({1'b0, v0} + {1'b0, v1} + {1'b0, v2}) : 2'd0;
      push.a = v0 ? r0 : (v1 ? r1 : r2);
      push.b = (v0 && v1) ? r1 : r2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/kvlp_queue.sv
// Small result queue: two writes and one read per cycle.
`default_nettype none
module kvlp_queue
   import kvlp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output rsp_type       head,
   output logic          not_empty,
   output logic          no_room
);

   rsp_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign not_empty = (count_ff != '0);
   // room for a full two-result transaction is required before accepting
   assign no_room   = (count_ff > QCNT_W'(QUEUE_DEPTH - 2));
   assign head      = mem_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.a;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 1'b1] <= push.b;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/kvlp_back.sv
// Back end: drains the queue into the registered result channel.
`default_nettype none
module kvlp_back
   import kvlp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire rsp_type head,
   input  wire logic    not_empty,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    load;

   assign load = ~rsp_valid_ff | ~rsp_stall;
   assign pop  = load & not_empty;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = not_empty;
         rsp_data_in  = head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/key_value_line_parser_unit.sv
// Top level of the key/value line parser.
// Input channel (req_): one text byte per transaction plus a buffer-start flag.
// Result channel (rsp_): key bytes, value bytes and accept/reject line marks,
// in order. A byte yields zero, one or two results.
// Path: a byte's results are written to the queue at the edge that accepts the
// byte and then pass through the output register to rsp_; older queued
// results come out first.
// Throughput: one byte per cycle while each byte yields at most one result and
// rsp_stall is low; the single result port drains the four-entry queue at one
// result per cycle, so bytes with two results use twice the output bandwidth.
// req_stall is high when the queue lacks room for two more results; it is
// decoded from the registered queue count and does not depend on req_valid.
// When the receiver stalls, rsp_data holds and the queue fills, after which
// req_stall rises; nothing is lost or repeated.
// Reset clears the line state, the queue pointers and count and the output
// valid flag; the block can take a byte as soon as reset is low.
`default_nettype none
module key_value_line_parser_unit
   import kvlp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   push_type push;
   rsp_type  head;
   logic     not_empty;
   logic     no_room;
   logic     pop;
   logic     req_accept;

   assign req_stall  = no_room;
   assign req_accept = req_valid & ~no_room;

   kvlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .push       (push)
   );

   kvlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .no_room   (no_room)
   );

   kvlp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for the key/value line parser: per-byte result prediction and in-order stream check.
module tb;
   import kvlp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   key_value_line_parser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted line state
   logic             in_value;
   logic [CNT_W-1:0] key_len;
   logic [CNT_W-1:0] value_len;
   logic             key_kept;
   logic             value_kept;
   logic             cr_waiting;
   logic             line_busy;
   logic             too_long;

   rsp_type    pending_items[$];
   logic [7:0] line_buf[$];
   int         start_at = -1;
   int         items_sent = 0;
   int         mismatches = 0;
   int         cycle_count = 0;
   int         hold_request = 0;
   int         hold_left = 0;
   int         burst_left = 0;
   bit         idling_on = 1'b1;

   task automatic clear_line_state();
      in_value = 1'b0;
      key_len = '0;
      value_len = '0;
      key_kept = 1'b0;
      value_kept = 1'b0;
      cr_waiting = 1'b0;
      line_busy = 1'b0;
      too_long = 1'b0;
   endtask

   task automatic push_result(input logic [7:0] b, input logic [1:0] kind);
      rsp_type r;
      r.out_byte = b;
      r.item_kind = kind;
      pending_items.push_back(r);
   endtask

   task automatic take_plain(input logic [7:0] b);
      line_busy = 1'b1;
      if (!in_value) begin
         if (b == CH_EQ) begin
            in_value = 1'b1;
         end else begin
            if (key_len < KEY_LIMIT) key_len = key_len + 1'b1;
            else too_long = 1'b1;
            if (key_kept || b != CH_SP) begin
               key_kept = 1'b1;
               push_result(b, KIND_KEY);
            end
         end
      end else begin
         if (value_len < VALUE_LIMIT) value_len = value_len + 1'b1;
         else too_long = 1'b1;
         if (value_kept || b != CH_SP) begin
            value_kept = 1'b1;
            push_result(b, KIND_VALUE);
         end
      end
   endtask

   task automatic parse_byte(input req_type it);
      logic ok;
      if (it.buffer_start) begin
         if (line_busy || cr_waiting) push_result(8'h00, KIND_REJECT);
         clear_line_state();
      end
      if (it.data_byte == CH_LF) begin
         ok = in_value && key_len >= 1 && value_len >= 1 && !too_long;
         push_result(8'h00, ok ? KIND_ACCEPT : KIND_REJECT);
         clear_line_state();
      end else begin
         // a held CR that is not followed by LF counts as an ordinary byte
         if (cr_waiting) begin
            cr_waiting = 1'b0;
            take_plain(CH_CR);
         end
         if (it.data_byte == CH_CR) begin
            cr_waiting = 1'b1;
            line_busy = 1'b1;
         end else begin
            take_plain(it.data_byte);
         end
      end
   endtask

   // Called just after a rising edge; returns at the edge that accepts the transaction.
   task automatic send_byte(input logic [7:0] b, input logic first);
      req_type it;
      it.data_byte = b;
      it.buffer_start = first;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      parse_byte(it);
      items_sent++;
   endtask

   task automatic send_line_buf();
      for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == start_at);
      line_buf.delete();
      start_at = -1;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_items.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   function automatic logic [7:0] field_byte(input bit is_value, input bit ctrl_ok,
                                             input bit lead);
      int r;
      logic [7:0] b;
      r = $urandom_range(0, 15);
      if ((lead && r < 6) || r == 0) return CH_SP;
      if (ctrl_ok && r == 1) return CH_CR;
      if (ctrl_ok && r == 2) begin
         b = 8'($urandom_range(0, 255));
         if (b == CH_LF || (!is_value && b == CH_EQ)) b = b | 8'h80;
         return b;
      end
      if (is_value && r == 3) return CH_EQ;
      do b = 8'($urandom_range(8'h21, 8'h7E)); while (b == CH_EQ);
      return b;
   endfunction

   task automatic add_field(input int n, input bit is_value, input bit ctrl_ok);
      for (int i = 0; i < n; i++) line_buf.push_back(field_byte(is_value, ctrl_ok, i < 2));
   endtask

   task automatic add_end(input bit crlf);
      if (crlf) line_buf.push_back(CH_CR);
      line_buf.push_back(CH_LF);
   endtask

   task automatic add_good_line();
      add_field($urandom_range(1, 8), 1'b0, 1'b1);
      line_buf.push_back(CH_EQ);
      add_field($urandom_range(1, 10), 1'b1, 1'b1);
      add_end(1'($urandom_range(0, 1)));
   endtask

   task automatic send_random_line();
      int pick;
      pick = $urandom_range(0, 99);
      start_at = ($urandom_range(0, 7) == 0) ? 0 : -1;
      if (pick < 70) begin
         add_good_line();
      end else if (pick < 78) begin
         // around the key or value length limit
         if ($urandom_range(0, 1)) begin
            add_field($urandom_range(KEY_LIMIT - 1, KEY_LIMIT + 3), 1'b0, 1'b1);
            line_buf.push_back(CH_EQ);
            add_field($urandom_range(1, 6), 1'b1, 1'b1);
         end else begin
            add_field($urandom_range(1, 6), 1'b0, 1'b1);
            line_buf.push_back(CH_EQ);
            add_field($urandom_range(VALUE_LIMIT - 1, VALUE_LIMIT + 3), 1'b1, 1'b1);
         end
         add_end(1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
         case ($urandom_range(0, 6))
            0: begin
               add_field($urandom_range(1, 8), 1'b0, 1'b1);
               add_end(1'($urandom_range(0, 1)));
            end
            1: begin
               line_buf.push_back(CH_EQ);
               add_field($urandom_range(1, 8), 1'b1, 1'b1);
               add_end(1'($urandom_range(0, 1)));
            end
            2: begin
               add_field($urandom_range(1, 8), 1'b0, 1'b1);
               line_buf.push_back(CH_EQ);
               add_end(1'($urandom_range(0, 1)));
            end
            3: add_end(1'($urandom_range(0, 1)));
            4: begin
               add_good_line();
               start_at = $urandom_range(1, line_buf.size() - 1);
            end
            5: begin
               add_field($urandom_range(1, 4), 1'b0, 1'b1);
               line_buf.push_back(CH_CR);
               line_buf.push_back(CH_CR);
               line_buf.push_back(CH_EQ);
               add_field($urandom_range(1, 4), 1'b1, 1'b1);
               line_buf.push_back(CH_CR);
               line_buf.push_back(CH_CR);
               line_buf.push_back(CH_LF);
            end
            default: begin
               // no terminator: the next line runs on from this one
               add_field($urandom_range(1, 6), 1'b0, 1'b1);
               line_buf.push_back(CH_EQ);
               add_field($urandom_range(0, 6), 1'b1, 1'b1);
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 16)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_line_buf();
   endtask

   task automatic test_directed();
      append_text(" a= b");
      add_end(1'b1);
      append_text("=x");
      add_end(1'b0);
      append_text("k=");
      add_end(1'b0);
      add_end(1'b0);
      append_text("ab");
      add_end(1'b0);
      line_buf.push_back(8'h00);
      line_buf.push_back(CH_CR);
      line_buf.push_back(CH_CR);
      line_buf.push_back(CH_EQ);
      line_buf.push_back(8'hFF);
      start_at = 0;
      send_line_buf();
      // new buffer while a line is open with no terminator
      append_text("q==");
      add_end(1'b0);
      start_at = 0;
      send_line_buf();
      wait_drained();
   endtask

   task automatic test_length_limits();
      for (int i = 0; i < 4; i++) begin
         add_field((i < 2) ? KEY_LIMIT + i : 3, 1'b0, 1'b0);
         line_buf.push_back(CH_EQ);
         add_field((i < 2) ? 3 : VALUE_LIMIT + i - 2, 1'b1, 1'b0);
         add_end(i[0]);
         send_line_buf();
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_request = 300;
      repeat (8) begin
         add_good_line();
         send_line_buf();
      end
      wait_drained();
   endtask

   task automatic test_random_lines(input int target);
      while (items_sent < target) send_random_line();
   endtask

   task automatic test_no_idling(input int target);
      idling_on = 1'b0;
      while (items_sent < target) send_random_line();
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(1, 15) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_items.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: byte %h kind %0d", rsp_data.out_byte,
                        rsp_data.item_kind);
         end else begin
            want = pending_items.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.item_kind !== want.item_kind) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected byte %h kind %0d, got byte %h kind %0d",
                           want.out_byte, want.item_kind, rsp_data.out_byte,
                           rsp_data.item_kind);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      clear_line_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_length_limits();
      test_backpressure();
      test_random_lines(1750);
      test_no_idling(1950);
      if (mismatches == 0 && pending_items.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
